// ===== rtl/dlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfd_pkg: shared definitions for the link frame deframer
// Result codes, frame constants, register indexes and the result item type.
// ----------------------------------------------------------------------------
package dlfd_pkg;

    // Frame header constants.
    localparam logic [31:0] FRAME_MAGIC     = 32'hFEEE_EEEF;
    localparam logic [31:0] DT_PROTOCOL     = 32'd1;
    localparam logic [31:0] DT_MSG          = 32'd2;
    localparam logic [31:0] PRIO_BYTES      = 32'd4;

    // Register reset values.
    localparam logic [31:0] DEFAULT_MAX_LEN  = 32'h0040_0000;
    localparam logic [7:0]  DEFAULT_LOG_SKIP = 8'd16;

    // Configuration port layout.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_LEN  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_LOG_SKIP = 1'b1;

    // Depth of the result queue; it must hold at least two items.
    localparam int RES_FIFO_DEPTH = 4;

    // Result item codes.
    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_BAD_MAGIC = 3'd2,
        KIND_TOO_LONG  = 3'd3,
        KIND_FLOOD     = 3'd4
    } kind_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [31:0] frame_type;
        logic        to_log;
        logic        end_of_frame;
        logic        last;
    } result_t;

    // Results produced by one accepted byte: at most two.
    typedef struct packed {
        logic    vld0;
        logic    vld1;
        result_t res0;
        result_t res1;
    } push_t;

    // Build a result item with the last flag clear.
    function automatic result_t make_result(kind_t k, logic [7:0] d, logic [31:0] t,
                                            logic lg, logic eof);
        result_t r;
        r.kind         = k;
        r.data_byte    = d;
        r.frame_type   = t;
        r.to_log       = lg;
        r.end_of_frame = eof;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/dlfd_parser.sv =====
// ----------------------------------------------------------------------------
// dlfd_parser: header gathering, checks and payload tagging
// Holds the frame state and the two registers, and turns each accepted byte
// into zero, one or two result items for the result queue.
// ----------------------------------------------------------------------------
module dlfd_parser
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        rx_byte,
    input  logic                              cfg_we,
    input  logic [dlfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dlfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dlfd_pkg::push_t                   push
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PRIO    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] left_reg, left_next;
    logic [7:0]  run_reg, run_next;
    logic [31:0] max_len_reg;
    logic [7:0]  max_skip_reg;

    logic [3:0]  idx_inc;
    logic [7:0]  run_p1;
    logic [7:0]  run_end;
    logic [31:0] len_full;
    logic [31:0] left_dec;
    logic        to_log;
    logic        flood;
    logic        frame_end;

    // Values shared by several branches.
    assign idx_inc  = idx_reg + 4'd1;
    assign run_p1   = run_reg + 8'd1;
    assign len_full = {rx_byte, length_reg[31:8]};
    assign left_dec = left_reg - 32'd1;
    assign to_log   = (type_reg != dlfd_pkg::DT_PROTOCOL);
    assign flood    = to_log && (run_p1 >= max_skip_reg);
    assign run_end  = (!to_log || flood) ? 8'd0 : run_p1;

    // Next state and result items for the byte on the input.
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        magic_next  = magic_reg;
        type_next   = type_reg;
        length_next = length_reg;
        left_next   = left_reg;
        run_next    = run_reg;
        frame_end   = 1'b0;
        push.vld0   = 1'b0;
        push.vld1   = 1'b0;
        push.res0   = dlfd_pkg::make_result(dlfd_pkg::KIND_PAYLOAD, rx_byte, type_reg,
                                            to_log, 1'b0);
        push.res1   = dlfd_pkg::make_result(dlfd_pkg::KIND_FLOOD, 8'd0, type_reg,
                                            1'b1, 1'b0);
        if (accept)
        begin
            unique case (phase_reg)
                PH_PRIO:
                begin
                    idx_next = idx_inc;
                    if (idx_inc >= 4'd4)
                    begin
                        idx_next = 4'd0;
                        if (left_reg == 32'd0)
                        begin
                            push.vld0 = 1'b1;
                            push.res0 = dlfd_pkg::make_result(dlfd_pkg::KIND_EMPTY, 8'd0,
                                                              type_reg, to_log, 1'b1);
                            frame_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    push.vld0 = 1'b1;
                    push.res0 = dlfd_pkg::make_result(dlfd_pkg::KIND_PAYLOAD, rx_byte,
                                                      type_reg, to_log, left_dec == 32'd0);
                    frame_end = (left_dec == 32'd0);
                end
                default:
                begin
                    // Header hunting; the unused phase code lands here as well.
                    phase_next = PH_HEADER;
                    if (idx_reg < 4'd4)
                        magic_next = {rx_byte, magic_reg[31:8]};
                    else if (idx_reg < 4'd8)
                        type_next = {rx_byte, type_reg[31:8]};
                    else
                        length_next = len_full;
                    idx_next = idx_inc;
                    if (idx_inc >= 4'd12)
                    begin
                        idx_next = 4'd0;
                        if (magic_reg != dlfd_pkg::FRAME_MAGIC)
                        begin
                            push.vld0 = 1'b1;
                            push.res0 = dlfd_pkg::make_result(dlfd_pkg::KIND_BAD_MAGIC, 8'd0,
                                                              type_reg, 1'b0, 1'b0);
                            run_next  = 8'd0;
                        end
                        else if (len_full > max_len_reg)
                        begin
                            push.vld0 = 1'b1;
                            push.res0 = dlfd_pkg::make_result(dlfd_pkg::KIND_TOO_LONG, 8'd0,
                                                              type_reg, 1'b0, 1'b0);
                            run_next  = 8'd0;
                        end
                        else if (type_reg == dlfd_pkg::DT_MSG)
                        begin
                            // The priority word is dropped from the declared length.
                            left_next  = (len_full >= dlfd_pkg::PRIO_BYTES) ?
                                         len_full - dlfd_pkg::PRIO_BYTES : 32'd0;
                            phase_next = PH_PRIO;
                        end
                        else
                        begin
                            left_next = len_full;
                            if (len_full == 32'd0)
                            begin
                                push.vld0 = 1'b1;
                                push.res0 = dlfd_pkg::make_result(dlfd_pkg::KIND_EMPTY, 8'd0,
                                                                  type_reg, to_log, 1'b1);
                                frame_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
            endcase

            // Frame end: count log frames and flag a flood as a second item.
            if (frame_end)
            begin
                phase_next = PH_HEADER;
                idx_next   = 4'd0;
                run_next   = run_end;
                push.vld1  = flood;
            end
        end
        push.res0.last = !push.vld1;
        push.res1.last = 1'b1;
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            idx_reg    <= 4'd0;
            magic_reg  <= 32'd0;
            type_reg   <= 32'd0;
            length_reg <= 32'd0;
            left_reg   <= 32'd0;
            run_reg    <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            magic_reg  <= magic_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            run_reg    <= run_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= dlfd_pkg::DEFAULT_MAX_LEN;
            max_skip_reg <= dlfd_pkg::DEFAULT_LOG_SKIP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dlfd_pkg::CFG_IDX_MAX_LEN:  max_len_reg  <= cfg_data;
                dlfd_pkg::CFG_IDX_LOG_SKIP: max_skip_reg <= cfg_data[7:0];
                default:                    max_len_reg  <= max_len_reg;
            endcase
        end
    end

`ifndef SYNTH
    // A flood item only ever follows the ending item of a frame.
    a_second_is_flood: assert property (@(posedge clk) disable iff (!rst_n)
        push.vld1 |-> push.vld0 && push.res0.end_of_frame &&
                      push.res1.kind == dlfd_pkg::KIND_FLOOD)
        else $error("second item is not a flood after a frame end");

    // The payload phase always has bytes left to pass on.
    a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    // A frame end sends the block back to header hunting at index zero.
    a_end_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> phase_reg == PH_HEADER && idx_reg == 4'd0)
        else $error("frame end did not return to header hunting");
`endif

endmodule

// ===== rtl/dlfd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// dlfd_out_fifo: result queue
// Takes up to two result items per cycle and hands out one per cycle while out_stall is low.
// Stalls the input side when fewer than two entries are free.
// ----------------------------------------------------------------------------
module dlfd_out_fifo
#(
    parameter int DEPTH = dlfd_pkg::RES_FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dlfd_pkg::push_t   push,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output dlfd_pkg::result_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dlfd_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_p1, wr_p2, rd_p1;
    logic [1:0]        push_n;
    logic              pop;

    // Pointer steps with wrap at the queue depth.
    assign wr_p1 = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
    assign wr_p2 = (wr_p1 == PTR_W'(DEPTH - 1)) ? '0 : wr_p1 + PTR_W'(1);
    assign rd_p1 = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);

    assign pop       = out_valid && !out_stall;
    assign push_n    = {1'b0, push.vld0} + {1'b0, push.vld1};
    assign out_valid = (count_reg != '0);
    assign in_stall  = (count_reg > CNT_W'(DEPTH - 2));
    assign head      = mem_reg[rd_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_next    = push.vld1 ? wr_p2 : (push.vld0 ? wr_p1 : wr_reg);
        rd_next    = pop ? rd_p1 : rd_reg;
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Entry storage; a second item goes into the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.vld0)
            mem_reg[wr_reg] <= push.res0;
        if (push.vld1)
            mem_reg[wr_p1] <= push.res1;
    end

`ifndef SYNTH
    // The fill level never passes the depth.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");
`endif

endmodule

// ===== rtl/download_link_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// download_link_frame_deframer_unit: link frame deframer, top level
// Gathers frame headers from received link bytes and passes payload on.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while rx_stall is low, and
// its results are written into a small result queue (RES_DEPTH entries) and
// handed out one result item per cycle while out_stall is low. Every byte is
// handled in a single pass of logic in the frame parser, so a new byte can
// enter in every cycle while rx_stall is low. A byte that ends a frame and
// also trips the log flood count gives two items; rx_stall rises while fewer
// than two queue entries are free. Registers are written through cfg_we,
// cfg_addr and cfg_data: index 0 is max_frame_length, index 1 is max_log_skip.
// The user must write them only while the block is idle; it is not enforced.
module download_link_frame_deframer_unit
#(
    parameter int RES_DEPTH = dlfd_pkg::RES_FIFO_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rx_valid,
    output logic                              rx_stall,
    input  logic [7:0]                        rx_byte,
    input  logic                              cfg_we,
    input  logic [dlfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dlfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [7:0]                        data_byte,
    output logic [31:0]                       frame_type,
    output logic                              to_log,
    output logic                              end_of_frame,
    output logic                              last
);

    dlfd_pkg::push_t   push;
    dlfd_pkg::result_t head;
    logic              accept;

    assign accept = rx_valid && !rx_stall;

    // Frame parser.
    dlfd_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .push     (push)
    );

    // Result queue.
    dlfd_out_fifo #(.DEPTH(RES_DEPTH)) u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_stall  (rx_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Result fields.
    assign kind         = head.kind;
    assign data_byte    = head.data_byte;
    assign frame_type   = head.frame_type;
    assign to_log       = head.to_log;
    assign end_of_frame = head.end_of_frame;
    assign last         = head.last;

endmodule
